@@ rtl/cbpp_pkg.sv @@
`default_nettype none
package cbpp_pkg;

    // defaults for the top-level parameters
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 32;

    // fixed port widths
    localparam int KIND_W   = 2;
    localparam int PAGE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 6;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEW   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FLUSH  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_SWEEP,
        ST_FLUSH
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // latch request, park flush pointer at the hand
        logic match;       // register the tag compare vector
        logic emit_hit;    // report hit, mark used on a get
        logic emit_full;   // report pool full, clear every used bit
        logic sweep_step;  // second chance: clear used bit at hand, advance
        logic place;       // evict or take frame at hand, report load
        logic flush_empty; // report the single entry of an empty flush
        logic flush_emit;  // report and free the frame at the flush pointer
        logic flush_skip;  // move the flush pointer past an empty frame
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit;         // registered compare found the page
        logic all_used;    // every frame present and used
        logic hand_pu;     // frame at the hand is present and used
        logic slot_free;   // output register can take a beat this cycle
        logic any_present; // at least one frame present
        logic ptr_present; // frame at the flush pointer is present
        logic only_one;    // that frame is the last one present
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/cbpp_ctrl.sv @@
`default_nettype none
module cbpp_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic [cbpp_pkg::KIND_W-1:0]   i_kind,
    output logic                               o_in_ready,
    input  wire cbpp_pkg::t_dp_sts             i_sts,
    output cbpp_pkg::t_dp_cmd                  o_cmd
);
    import cbpp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_GET || i_kind == KIND_NEW) begin
                        n_state = ST_MATCH;
                    end else if (i_kind == KIND_FLUSH) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_MATCH: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_sts.hit || i_sts.all_used) begin
                    if (i_sts.slot_free) n_state = ST_IDLE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!i_sts.hand_pu && i_sts.slot_free) n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (!i_sts.any_present) begin
                    if (i_sts.slot_free) n_state = ST_IDLE;
                end else if (i_sts.ptr_present && i_sts.slot_free && i_sts.only_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MATCH: o_cmd.match = 1'b1;
            ST_DECIDE: begin
                if (i_sts.hit) begin
                    o_cmd.emit_hit = i_sts.slot_free;
                end else if (i_sts.all_used) begin
                    o_cmd.emit_full = i_sts.slot_free;
                end
            end
            ST_SWEEP: begin
                if (i_sts.hand_pu) begin
                    o_cmd.sweep_step = 1'b1;
                end else begin
                    o_cmd.place = i_sts.slot_free;
                end
            end
            ST_FLUSH: begin
                if (!i_sts.any_present) begin
                    o_cmd.flush_empty = i_sts.slot_free;
                end else if (i_sts.ptr_present) begin
                    o_cmd.flush_emit = i_sts.slot_free;
                end else begin
                    o_cmd.flush_skip = 1'b1;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/cbpp_dp.sv @@
`default_nettype none
module cbpp_dp #(
    parameter int FRAMES    = cbpp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = cbpp_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [cbpp_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [cbpp_pkg::PAGE_W-1:0]     i_page_number,
    input  wire cbpp_pkg::t_dp_cmd               i_cmd,
    output cbpp_pkg::t_dp_sts                    o_sts,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [cbpp_pkg::STATUS_W-1:0]        o_status,
    output logic [cbpp_pkg::FIDX_W-1:0]          o_frame_index,
    output logic                                 o_write_back,
    output logic [cbpp_pkg::PAGE_W-1:0]          o_write_back_page,
    output logic                                 o_last
);
    import cbpp_pkg::*;

    localparam int HW    = $clog2(FRAMES);
    localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam logic [HW-1:0] HAND_MAX = HW'(FRAMES - 1);

    // frame state
    logic [TAG_W-1:0]  r_tag [FRAMES];
    logic [TAG_W-1:0]  n_tag [FRAMES];
    logic [FRAMES-1:0] r_present, n_present;
    logic [FRAMES-1:0] r_used, n_used;
    logic [HW-1:0]     r_hand, n_hand;

    // request context
    logic [TAG_W-1:0]  r_page, n_page;
    logic              r_is_get, n_is_get;
    logic [HW-1:0]     r_ptr, n_ptr;
    logic [FRAMES-1:0] r_hit_vec, n_hit_vec;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [FIDX_W-1:0]   r_out_frame, n_out_frame;
    logic                r_out_wb, n_out_wb;
    logic [PAGE_W-1:0]   r_out_wb_page, n_out_wb_page;
    logic                r_out_last, n_out_last;

    logic [HW-1:0]     hit_idx;
    logic [HW-1:0]     hand_next;
    logic [HW-1:0]     ptr_next;
    logic [FRAMES-1:0] ptr_mask;
    logic              slot_free;

    assign hand_next = (r_hand == HAND_MAX) ? '0 : r_hand + 1'b1;
    assign ptr_next  = (r_ptr == HAND_MAX) ? '0 : r_ptr + 1'b1;
    assign ptr_mask  = FRAMES'(1) << r_ptr;
    assign slot_free = !r_out_valid || i_out_ready;

    // at most one present frame holds a given page
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (r_hit_vec[i]) hit_idx = hit_idx | HW'(i);
        end
    end

    always_comb begin
        o_sts.hit         = |r_hit_vec;
        o_sts.all_used    = &(r_present & r_used);
        o_sts.hand_pu     = r_present[r_hand] && r_used[r_hand];
        o_sts.slot_free   = slot_free;
        o_sts.any_present = |r_present;
        o_sts.ptr_present = r_present[r_ptr];
        o_sts.only_one    = (r_present & ~ptr_mask) == '0;
    end

    always_comb begin
        n_tag         = r_tag;
        n_present     = r_present;
        n_used        = r_used;
        n_hand        = r_hand;
        n_page        = r_page;
        n_is_get      = r_is_get;
        n_ptr         = r_ptr;
        n_hit_vec     = r_hit_vec;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_frame   = r_out_frame;
        n_out_wb      = r_out_wb;
        n_out_wb_page = r_out_wb_page;
        n_out_last    = r_out_last;

        if (i_cmd.load) begin
            n_page   = TAG_W'(i_page_number);
            n_is_get = (i_kind == KIND_GET);
            n_ptr    = r_hand;
        end

        if (i_cmd.match) begin
            for (int i = 0; i < FRAMES; i++) begin
                n_hit_vec[i] = r_present[i] && (r_tag[i] == r_page);
            end
        end

        if (i_cmd.emit_hit) begin
            if (r_is_get) n_used[hit_idx] = 1'b1;
            n_out_valid   = 1'b1;
            n_out_status  = STATUS_HIT;
            n_out_frame   = FIDX_W'(hit_idx);
            n_out_wb      = 1'b0;
            n_out_wb_page = '0;
            n_out_last    = 1'b1;
        end

        // a full sweep would clear every used bit and bring the hand back
        if (i_cmd.emit_full) begin
            n_used        = '0;
            n_out_valid   = 1'b1;
            n_out_status  = STATUS_FULL;
            n_out_frame   = FIDX_W'(r_hand);
            n_out_wb      = 1'b0;
            n_out_wb_page = '0;
            n_out_last    = 1'b1;
        end

        if (i_cmd.sweep_step) begin
            n_used[r_hand] = 1'b0;
            n_hand         = hand_next;
        end

        if (i_cmd.place) begin
            n_out_valid      = 1'b1;
            n_out_status     = STATUS_LOADED;
            n_out_frame      = FIDX_W'(r_hand);
            n_out_wb         = r_present[r_hand];
            n_out_wb_page    = r_present[r_hand] ? PAGE_W'(r_tag[r_hand]) : '0;
            n_out_last       = 1'b1;
            n_tag[r_hand]    = r_page;
            n_present[r_hand] = 1'b1;
            n_used[r_hand]   = r_is_get;
            n_hand           = hand_next;
        end

        if (i_cmd.flush_empty) begin
            n_out_valid   = 1'b1;
            n_out_status  = STATUS_FLUSH;
            n_out_frame   = FIDX_W'(r_hand);
            n_out_wb      = 1'b0;
            n_out_wb_page = '0;
            n_out_last    = 1'b1;
        end

        if (i_cmd.flush_emit) begin
            n_out_valid      = 1'b1;
            n_out_status     = STATUS_FLUSH;
            n_out_frame      = FIDX_W'(r_ptr);
            n_out_wb         = 1'b1;
            n_out_wb_page    = PAGE_W'(r_tag[r_ptr]);
            n_out_last       = o_sts.only_one;
            n_present[r_ptr] = 1'b0;
            n_ptr            = ptr_next;
        end

        if (i_cmd.flush_skip) begin
            n_ptr = ptr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= '0;
            r_used      <= '0;
            r_hand      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_present   <= n_present;
            r_used      <= n_used;
            r_hand      <= n_hand;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag         <= n_tag;
        r_page        <= n_page;
        r_is_get      <= n_is_get;
        r_ptr         <= n_ptr;
        r_hit_vec     <= n_hit_vec;
        r_out_status  <= n_out_status;
        r_out_frame   <= n_out_frame;
        r_out_wb      <= n_out_wb;
        r_out_wb_page <= n_out_wb_page;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_frame_index     = r_out_frame;
    assign o_write_back      = r_out_wb;
    assign o_write_back_page = r_out_wb_page;
    assign o_last            = r_out_last;

endmodule
`default_nettype wire

@@ rtl/clock_buffer_pool_pager.sv @@
// lookup: a hit passes the request, compare and output registers; a miss adds the
//   sweep, where the hand clears the used bit of each second-chance frame it passes
// one request at a time, and output stalls hold a lookup; a flush walks the frames
//   from the hand, reporting and freeing each present frame, and waits on output stalls
// reset: synchronous active low, empties all frames, clears used bits, hand to zero
`default_nettype none
module clock_buffer_pool_pager #(
    parameter int FRAMES    = cbpp_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = cbpp_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [cbpp_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [cbpp_pkg::PAGE_W-1:0]     i_page_number,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [cbpp_pkg::STATUS_W-1:0]        o_status,
    output logic [cbpp_pkg::FIDX_W-1:0]          o_frame_index,
    output logic                                 o_write_back,
    output logic [cbpp_pkg::PAGE_W-1:0]          o_write_back_page,
    output logic                                 o_last
);
    import cbpp_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // controller: decides hit, full pool, sweep and flush walk;
    // only takes a request beat while idle
    cbpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: tag cells with parallel compare, present and used bits,
    // clock hand, flush pointer and the output register
    cbpp_dp #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_kind            (i_kind),
        .i_page_number     (i_page_number),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_frame_index     (o_frame_index),
        .o_write_back      (o_write_back),
        .o_write_back_page (o_write_back_page),
        .o_last            (o_last)
    );

    // a get or new beat is never followed by another accept on the next edge
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_kind == KIND_GET || i_kind == KIND_NEW))
            |=> !o_in_ready)
        else $error("request taken while lookup in progress");

    // lookups give exactly one beat, so it is always the last
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_FLUSH) |-> o_last)
        else $error("lookup result without last");

    // write-back only on an eviction or a flush entry
    a_wb_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_back) |->
            (o_status == STATUS_LOADED || o_status == STATUS_FLUSH))
        else $error("write-back on hit or full pool");

    // no write-back means a zero page
    a_wb_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_back) |-> (o_write_back_page == '0))
        else $error("stale write-back page");

endmodule
`default_nettype wire
